/* hdl/mapc_pkg.sv */
// Shared types, widths and constants for the moving-average pressure calibrator.
// Used by every module under hdl; depends on nothing else.
package mapc_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int OUT_W       = 14;
    localparam int GAIN_W      = 18;
    localparam int OFFSET_W    = 29;
    localparam int DB_W        = 8;
    localparam int PROD_W      = GAIN_W + SAMPLE_W;
    localparam int MAG_W       = PROD_W - 16 + 1;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam int WINDOW_LENGTH_DEF = 30;

    localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(123575);
    localparam logic [OFFSET_W-1:0] OFFSET_RST = OFFSET_W'(173244416);
    localparam logic [DB_W-1:0]     DB_RST     = DB_W'(20);

    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DB     = 2'd2;

    localparam logic [MAG_W-1:0] OUT_POS_LIMIT = MAG_W'(8191);
    localparam logic [MAG_W-1:0] OUT_NEG_LIMIT = MAG_W'(8192);

    typedef struct packed {
        logic [GAIN_W-1:0]   gain_q16;
        logic [OFFSET_W-1:0] offset_q16;
        logic [DB_W-1:0]     dead_band;
    } cfg_t;

    // Width of the running sum of a window of full-scale samples.
    function automatic int sum_width(input int n);
        return $clog2(n * ((1 << SAMPLE_W) - 1) + 1);
    endfunction

endpackage

/* hdl/moving_average_pressure_calibrator.sv */
// Moving-average pressure calibrator, top level. Depends on mapc_pkg and all mapc_* modules.
// Each accepted sample passes through the sum, average, product and result registers
// in that order. Throughput: one item per cycle; the four-stage
// pipeline only stalls when the result register is held by m_tready low.
// Reset: rst_n clears the sample window, running sum, valids and loads the
// default calibration; the block is ready to accept items as soon as reset is released.
module moving_average_pressure_calibrator #(
    parameter int WINDOW_LENGTH = mapc_pkg::WINDOW_LENGTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mapc_pkg::S_TDATA_W-1:0]   s_tdata,   // [11:0] sample_mv
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mapc_pkg::M_TDATA_W-1:0]   m_tdata,   // [13:0] pressure_pa
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mapc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mapc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mapc_pkg::*;

    localparam int SUM_W = sum_width(WINDOW_LENGTH);

    cfg_t                cfg;
    logic [SUM_W-1:0]    sum;
    logic [SAMPLE_W-1:0] avg;
    logic [OUT_W-1:0]    pressure_pa;
    logic                sum_valid;
    logic                avg_valid;
    logic                prod_valid;
    logic                en_out;
    logic                en_prod;
    logic                en_avg;
    logic                en_sum;
    logic                accept;

    assign en_out   = !m_tvalid || m_tready;
    assign en_prod  = !prod_valid || en_out;
    assign en_avg   = !avg_valid || en_prod;
    assign en_sum   = !sum_valid || en_avg;
    assign s_tready = en_sum;
    assign accept   = s_tvalid && s_tready;
    assign m_tdata  = {{(M_TDATA_W-OUT_W){1'b0}}, pressure_pa};

    mapc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mapc_window #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .en     (en_sum),
        .sample (s_tdata[SAMPLE_W-1:0]),
        .sum    (sum),
        .valid  (sum_valid)
    );

    mapc_avg #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_avg (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en_avg),
        .in_valid (sum_valid),
        .sum      (sum),
        .avg      (avg),
        .valid    (avg_valid)
    );

    mapc_calib u_calib (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .en_prod     (en_prod),
        .en_out      (en_out),
        .in_valid    (avg_valid),
        .avg         (avg),
        .prod_valid  (prod_valid),
        .out_valid   (m_tvalid),
        .pressure_pa (pressure_pa)
    );

`ifndef SYNTHESIS
    a_accept_fills_sum: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> sum_valid)
        else $error("accepted item did not reach the sum stage");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (sum_valid && avg_valid && prod_valid && m_tvalid && !m_tready))
        else $error("input stalled with a free pipeline slot");

    a_prod_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (prod_valid && !m_tvalid) |=> m_tvalid)
        else $error("product stage did not move into empty result register");

    a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        sum <= SUM_W'(WINDOW_LENGTH * ((1 << SAMPLE_W) - 1)))
        else $error("running sum exceeds full-scale window");
`endif

endmodule

/* hdl/mapc_cfg_regs.sv */
// Calibration register file written through the configuration channel.
// Depends on mapc_pkg.
module mapc_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mapc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mapc_pkg::CFG_DATA_W-1:0] cfg_data,
    output mapc_pkg::cfg_t                  cfg
);
    import mapc_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_q16   <= GAIN_RST;
            cfg_reg.offset_q16 <= OFFSET_RST;
            cfg_reg.dead_band  <= DB_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_GAIN:   cfg_reg.gain_q16   <= cfg_data[GAIN_W-1:0];
                REG_OFFSET: cfg_reg.offset_q16 <= cfg_data[OFFSET_W-1:0];
                REG_DB:     cfg_reg.dead_band  <= cfg_data[DB_W-1:0];
                default:    ;
            endcase
        end
    end

endmodule

/* hdl/mapc_window.sv */
// Sample shift line and running sum; the last tap is the oldest sample.
// Depends on mapc_pkg.
module mapc_window #(
    parameter int WINDOW_LENGTH = mapc_pkg::WINDOW_LENGTH_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            accept,
    input  logic                                            en,
    input  logic [mapc_pkg::SAMPLE_W-1:0]                   sample,
    output logic [mapc_pkg::sum_width(WINDOW_LENGTH)-1:0]   sum,
    output logic                                            valid
);
    import mapc_pkg::*;

    localparam int SUM_W = sum_width(WINDOW_LENGTH);

    logic [SAMPLE_W-1:0] window_reg [WINDOW_LENGTH];
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic                valid_reg;

    assign sum_next = sum_reg - SUM_W'(window_reg[WINDOW_LENGTH-1]) + SUM_W'(sample);
    assign sum      = sum_reg;
    assign valid    = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LENGTH; i++)
            begin
                window_reg[i] <= '0;
            end
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                window_reg[0] <= sample;
                for (int i = 1; i < WINDOW_LENGTH; i++)
                begin
                    window_reg[i] <= window_reg[i-1];
                end
                sum_reg <= sum_next;
            end
            if (en)
            begin
                valid_reg <= accept;
            end
        end
    end

endmodule

/* hdl/mapc_avg.sv */
// Window average: running sum divided by the window length via reciprocal multiply.
// Depends on mapc_pkg.
module mapc_avg #(
    parameter int WINDOW_LENGTH = mapc_pkg::WINDOW_LENGTH_DEF
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            en,
    input  logic                                            in_valid,
    input  logic [mapc_pkg::sum_width(WINDOW_LENGTH)-1:0]   sum,
    output logic [mapc_pkg::SAMPLE_W-1:0]                   avg,
    output logic                                            valid
);
    import mapc_pkg::*;

    localparam int SUM_W   = sum_width(WINDOW_LENGTH);
    localparam int SHIFT   = SUM_W + $clog2(WINDOW_LENGTH);
    localparam int RECIP_W = SUM_W + 1;
    localparam longint unsigned RECIP =
        ((64'd1 << SHIFT) + WINDOW_LENGTH - 1) / WINDOW_LENGTH;

    logic [SUM_W+RECIP_W-1:0] quot_full;
    logic [SAMPLE_W-1:0]      avg_reg;
    logic                     valid_reg;

    // Exact floor(sum / N) for every sum below 2^SUM_W.
    assign quot_full = (SUM_W+RECIP_W)'(sum) * (SUM_W+RECIP_W)'(RECIP_W'(RECIP));
    assign avg       = avg_reg;
    assign valid     = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            avg_reg <= quot_full[SHIFT +: SAMPLE_W];
        end
    end

endmodule

/* hdl/mapc_calib.sv */
// Linear calibration: gain product, offset subtract, truncation toward zero,
// deadband and saturation into the result register. Depends on mapc_pkg.
module mapc_calib (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mapc_pkg::cfg_t                cfg,
    input  logic                          en_prod,
    input  logic                          en_out,
    input  logic                          in_valid,
    input  logic [mapc_pkg::SAMPLE_W-1:0] avg,
    output logic                          prod_valid,
    output logic                          out_valid,
    output logic [mapc_pkg::OUT_W-1:0]    pressure_pa
);
    import mapc_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic              prod_valid_reg;
    logic [OUT_W-1:0]  out_reg;
    logic              out_valid_reg;

    logic signed [PROD_W:0] diff;
    logic                   neg;
    logic [PROD_W:0]        abs_diff;
    logic [MAG_W-1:0]       mag;
    logic [OUT_W-1:0]       res_next;

    assign diff     = $signed({1'b0, prod_reg}) - $signed((PROD_W+1)'(cfg.offset_q16));
    assign neg      = diff[PROD_W];
    assign abs_diff = neg ? (PROD_W+1)'(-diff) : (PROD_W+1)'(diff);
    assign mag      = abs_diff[PROD_W:16];

    always_comb
    begin
        if (mag < MAG_W'(cfg.dead_band))
        begin
            res_next = '0;
        end
        else if (!neg)
        begin
            res_next = (mag > OUT_POS_LIMIT) ? OUT_W'(OUT_POS_LIMIT) : mag[OUT_W-1:0];
        end
        else
        begin
            res_next = (mag > OUT_NEG_LIMIT) ? OUT_W'(-OUT_NEG_LIMIT)
                                              : OUT_W'(-mag[OUT_W-1:0]);
        end
    end

    assign prod_valid  = prod_valid_reg;
    assign out_valid   = out_valid_reg;
    assign pressure_pa = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (en_prod)
            begin
                prod_valid_reg <= in_valid;
            end
            if (en_out)
            begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_prod && in_valid)
        begin
            prod_reg <= PROD_W'(cfg.gain_q16) * PROD_W'(avg);
        end
        if (en_out && prod_valid_reg)
        begin
            out_reg <= res_next;
        end
    end

endmodule
